@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Implication checks, same cycle and next cycle; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define DPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define DPE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/dpe_pkg.sv @@
// ---------------------------------------------------------------------------
// DPCM pixel encoder package
// Widths, register indexes, codes and inter-module structs.
// ---------------------------------------------------------------------------
package dpe_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int PIX_W      = 8;
   localparam int LW_W       = 11;
   localparam int MODE_W     = 2;
   localparam int STEP_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int VAL_W      = 10;
   localparam int CODE_OUT_W = 10;
   localparam int ARITH_W    = 12;
   localparam int DIV_W      = ARITH_W;
   localparam int DIVISOR_W  = STEP_W + 1;
   localparam int DIV_STEPS  = DIV_W / 2;

   localparam logic [LW_W-1:0]         LINE_WIDTH_RESET = 11'd1024;
   localparam logic [STEP_W-1:0]       QUANT_STEP_RESET = 7'd1;
   localparam logic signed [VAL_W-1:0] BORDER_VALUE     = 10'sd128;
   localparam logic [CODE_OUT_W-1:0]   CODE_OFFSET      = 10'd128;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRED_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_STEP = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      PRED_LEFT,
      PRED_AVERAGE,
      PRED_ADAPTIVE,
      PRED_COMPETITIVE
   } pred_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_RECON,
      S_WRITE
   } enc_state_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] pred;
      logic signed [VAL_W-1:0] above;
      pred_mode_type           sel;
   } pred_result_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic             rem_nonzero;
   } div_rsp_type;

endpackage

@@ hdl/dpe_row_mem.sv @@
// ---------------------------------------------------------------------------
// Row memory
// Reconstructed previous row, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module dpe_row_mem #(
   parameter int DEPTH  = dpe_pkg::MAX_WIDTH_DEFAULT,
   parameter int DATA_W = dpe_pkg::VAL_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/dpe_predictor.sv @@
// ---------------------------------------------------------------------------
// Predictor
// Border substitution, left/average/adaptive predictors and per-pixel choice.
// ---------------------------------------------------------------------------
module dpe_predictor (
   input  logic [dpe_pkg::PIX_W-1:0]        pixel,
   input  logic signed [dpe_pkg::VAL_W-1:0] above_raw,
   input  logic signed [dpe_pkg::VAL_W-1:0] upper_left,
   input  logic signed [dpe_pkg::VAL_W-1:0] left,
   input  logic                             first_row,
   input  logic                             col_zero,
   input  dpe_pkg::pred_mode_type           mode,
   output dpe_pkg::pred_result_type         result
);

   localparam int AW = dpe_pkg::ARITH_W;
   localparam int VW = dpe_pkg::VAL_W;

   logic signed [VW-1:0] a_v, b_v, c_v;
   logic signed [AW-1:0] a, b, c, x, sum_ac, p_avg, p_ada;
   logic signed [AW-1:0] dist_l, dist_v, dist_d;
   dpe_pkg::pred_mode_type sel;

   function automatic logic signed [AW-1:0] abs_diff(input logic signed [AW-1:0] p,
                                                      input logic signed [AW-1:0] q);
      return (p > q) ? p - q : q - p;
   endfunction

   always_comb begin
      a_v = first_row ? dpe_pkg::BORDER_VALUE : above_raw;
      b_v = (first_row || col_zero) ? dpe_pkg::BORDER_VALUE : upper_left;
      c_v = col_zero ? dpe_pkg::BORDER_VALUE : left;
      a = AW'(a_v);
      b = AW'(b_v);
      c = AW'(c_v);
      x = $signed({{(AW - dpe_pkg::PIX_W){1'b0}}, pixel});

      // floor half of the sum, exact for negative sums too
      sum_ac = a + c;
      p_avg  = (first_row && col_zero) ? AW'(dpe_pkg::BORDER_VALUE) : (sum_ac >>> 1);
      p_ada  = (abs_diff(c, b) < abs_diff(a, b)) ? a : b;

      dist_l = abs_diff(x, c);
      dist_v = abs_diff(x, p_avg);
      dist_d = abs_diff(x, p_ada);

      case (mode)
         dpe_pkg::PRED_LEFT:     sel = dpe_pkg::PRED_LEFT;
         dpe_pkg::PRED_AVERAGE:  sel = dpe_pkg::PRED_AVERAGE;
         dpe_pkg::PRED_ADAPTIVE: sel = dpe_pkg::PRED_ADAPTIVE;
         dpe_pkg::PRED_COMPETITIVE: begin
            // left wins only when strictly nearest; a left/average tie goes to average, other ties to adaptive
            if (dist_l < dist_v && dist_l < dist_d) begin
               sel = dpe_pkg::PRED_LEFT;
            end else if (dist_v < dist_d) begin
               sel = dpe_pkg::PRED_AVERAGE;
            end else begin
               sel = dpe_pkg::PRED_ADAPTIVE;
            end
         end
         default: sel = dpe_pkg::PRED_LEFT;
      endcase

      case (sel)
         dpe_pkg::PRED_LEFT:    result.pred = c[VW-1:0];
         dpe_pkg::PRED_AVERAGE: result.pred = p_avg[VW-1:0];
         default:               result.pred = p_ada[VW-1:0];
      endcase
      result.above = a_v;
      result.sel   = sel;
   end

endmodule

@@ hdl/dpe_divider.sv @@
// ---------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring division, two quotient bits per cycle.
// ---------------------------------------------------------------------------
module dpe_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  dpe_pkg::div_req_type req,
   output dpe_pkg::div_rsp_type rsp
);

   localparam int DW    = dpe_pkg::DIV_W;
   localparam int VW    = dpe_pkg::DIVISOR_W;
   localparam int STEPS = dpe_pkg::DIV_STEPS;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

   logic [DW-1:0]    acc_ff, acc_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [VW:0]      trial;

   // acc shifts the dividend out at the top and the quotient in at the bottom
   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, acc_in[DW-1]};
         acc_in = {acc_in[DW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial     = trial - {1'b0, dvs_ff};
            acc_in[0] = 1'b1;
         end
         rem_in = trial[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         acc_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.done        = done_ff;
   assign rsp.quotient    = acc_ff;
   assign rsp.rem_nonzero = |rem_ff;

endmodule

@@ hdl/dpcm_pixel_encoder_top.sv @@
// ---------------------------------------------------------------------------
// DPCM pixel encoder, top level
// Closed-loop DPCM encoder with row memory, predictor and iterative divider.
// ---------------------------------------------------------------------------
// The result register loads when the write state finishes; each pixel first passes
// the row memory read, the radix-4 divider and the reconstruction write-back, and no
// new pixel is accepted before then, nor while the write waits on a stalled output.
// Reset clears the sequencer and output valid, sets configuration to defaults;
// the row memory is not cleared and needs no clearing pass.
module dpcm_pixel_encoder_top #(
   parameter int MAX_WIDTH = dpe_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dpe_pkg::PIX_W-1:0]             req_pixel,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dpe_pkg::CODE_OUT_W-1:0] rsp_residual_code,
   output logic [dpe_pkg::MODE_W-1:0]            rsp_predictor_used,
   input  logic                                  csr_write,
   input  logic [dpe_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dpe_pkg::CSR_DATA_W-1:0]        csr_data
);

`include "assert_macros.svh"

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = (COL_W > dpe_pkg::LW_W) ? COL_W : dpe_pkg::LW_W;
   localparam int AW     = dpe_pkg::ARITH_W;
   localparam int VW     = dpe_pkg::VAL_W;
   localparam int SW     = dpe_pkg::STEP_W;
   localparam logic [CMP_W-1:0] WIDTH_MAX = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0] WIDTH_MIN = CMP_W'(1);
   localparam logic [COL_W-1:0] COL_LAST  = COL_W'(MAX_WIDTH - 1);

   dpe_pkg::enc_state_type state_ff, state_in;

   logic [dpe_pkg::LW_W-1:0] lw_ff;
   dpe_pkg::pred_mode_type   mode_ff;
   logic [SW-1:0]            step_ff;

   logic [COL_W-1:0]     col_ff;
   logic                 first_row_ff;
   logic signed [VW-1:0] left_ff;
   logic signed [VW-1:0] ul_ff;

   logic [dpe_pkg::PIX_W-1:0] pixel_ff;
   dpe_pkg::pred_result_type  pred_ff;
   logic                      neg_ff;
   logic signed [AW-1:0]      code_ff;
   logic [VW-1:0]             prod_ff;

   logic                                  rsp_valid_ff;
   logic [dpe_pkg::CODE_OUT_W-1:0]        rsp_code_ff;
   dpe_pkg::pred_mode_type                rsp_sel_ff;

   logic                 accept, finish, out_free;
   logic [CMP_W-1:0]     lw_ext, width_eff;
   logic [SW-1:0]        q_eff;
   logic [COL_W-1:0]     col_start, col_acc, col_next;
   logic                 fr_start, fr_acc;
   logic [VW-1:0]        rd_data;
   dpe_pkg::pred_result_type pred_now;
   logic signed [AW-1:0] x_ext, diff, numer, adj, code_now;
   logic [AW-1:0]        numer_mag;
   logic signed [AW+SW:0] prod_full;
   logic signed [VW-1:0] recon;
   dpe_pkg::div_req_type div_req;
   dpe_pkg::div_rsp_type div_rsp;

   // effective configuration
   always_comb begin
      lw_ext = CMP_W'(lw_ff);
      if (lw_ext == '0) begin
         width_eff = WIDTH_MIN;
      end else if (lw_ext > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = lw_ext;
      end
      q_eff = (step_ff == '0) ? SW'(1) : step_ff;
   end

   // column at accept: frame start first, then wrap if the width shrank
   always_comb begin
      col_start = req_frame_start ? '0 : col_ff;
      fr_start  = req_frame_start | first_row_ff;
      if (CMP_W'(col_start) >= width_eff) begin
         col_acc = '0;
         fr_acc  = 1'b0;
      end else begin
         col_acc = col_start;
         fr_acc  = fr_start;
      end
      col_next = col_ff + 1'b1;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      finish   = 1'b0;
      case (state_ff)
         dpe_pkg::S_IDLE: begin
            if (req_valid) begin
               accept   = 1'b1;
               state_in = dpe_pkg::S_READ;
            end
         end
         dpe_pkg::S_READ:  state_in = dpe_pkg::S_DIV;
         dpe_pkg::S_DIV: begin
            if (div_rsp.done) begin
               state_in = dpe_pkg::S_RECON;
            end
         end
         dpe_pkg::S_RECON: state_in = dpe_pkg::S_WRITE;
         dpe_pkg::S_WRITE: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = dpe_pkg::S_IDLE;
            end
         end
         default: state_in = dpe_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpe_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != dpe_pkg::S_IDLE);

   dpe_row_mem #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (VW)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (finish),
      .wr_addr (col_ff[ADDR_W-1:0]),
      .wr_data (recon),
      .rd_en   (accept),
      .rd_addr (col_acc[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   dpe_predictor u_predictor (
      .pixel      (pixel_ff),
      .above_raw  ($signed(rd_data)),
      .upper_left (ul_ff),
      .left       (left_ff),
      .first_row  (first_row_ff),
      .col_zero   (col_ff == '0),
      .mode       (mode_ff),
      .result     (pred_now)
   );

   // dividend 2*(x - pred) + q, split into sign and magnitude
   always_comb begin
      x_ext     = $signed({{(AW - dpe_pkg::PIX_W){1'b0}}, pixel_ff});
      diff      = x_ext - AW'(pred_now.pred);
      numer     = (diff <<< 1) + $signed({{(AW - SW){1'b0}}, q_eff});
      numer_mag = numer[AW-1] ? AW'(-numer) : AW'(numer);
      div_req.start    = (state_ff == dpe_pkg::S_READ);
      div_req.dividend = numer_mag;
      div_req.divisor  = {q_eff, 1'b0};
   end

   dpe_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // floor division: round the magnitude up for negative dividends
   always_comb begin
      adj       = $signed(div_rsp.quotient + AW'(neg_ff && div_rsp.rem_nonzero));
      code_now  = neg_ff ? -adj : adj;
      prod_full = code_ff * $signed({1'b0, q_eff});
      recon     = pred_ff.pred + $signed(prod_ff);
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff        <= dpe_pkg::LINE_WIDTH_RESET;
         mode_ff      <= dpe_pkg::PRED_LEFT;
         step_ff      <= dpe_pkg::QUANT_STEP_RESET;
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         left_ff      <= dpe_pkg::BORDER_VALUE;
         ul_ff        <= dpe_pkg::BORDER_VALUE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               dpe_pkg::CSR_LINE_WIDTH: lw_ff <= csr_data[dpe_pkg::LW_W-1:0];
               dpe_pkg::CSR_PRED_MODE:
                  mode_ff <= dpe_pkg::pred_mode_type'(csr_data[dpe_pkg::MODE_W-1:0]);
               dpe_pkg::CSR_QUANT_STEP: step_ff <= csr_data[SW-1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            col_ff       <= col_acc;
            first_row_ff <= fr_acc;
            if (req_frame_start) begin
               left_ff <= dpe_pkg::BORDER_VALUE;
               ul_ff   <= dpe_pkg::BORDER_VALUE;
            end
         end
         if (finish) begin
            ul_ff   <= pred_ff.above;
            left_ff <= recon;
            if (CMP_W'(col_next) >= width_eff) begin
               col_ff       <= '0;
               first_row_ff <= 1'b0;
            end else begin
               col_ff <= col_next;
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff <= req_pixel;
      end
      if (state_ff == dpe_pkg::S_READ) begin
         pred_ff <= pred_now;
         neg_ff  <= numer[AW-1];
      end
      if (state_ff == dpe_pkg::S_DIV && div_rsp.done) begin
         code_ff <= code_now;
      end
      if (state_ff == dpe_pkg::S_RECON) begin
         prod_ff <= prod_full[VW-1:0];
      end
      if (finish) begin
         rsp_code_ff <= code_ff[dpe_pkg::CODE_OUT_W-1:0] + dpe_pkg::CODE_OFFSET;
         rsp_sel_ff  <= pred_ff.sel;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_residual_code  = $signed(rsp_code_ff);
   assign rsp_predictor_used = rsp_sel_ff;

   `DPE_ASSERT_IMPL(a_col_in_range, clock, reset, 1'b1, col_ff <= COL_LAST)
   `DPE_ASSERT_IMPL(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == dpe_pkg::S_WRITE)
   `DPE_ASSERT_IMPL(a_div_done_in_div, clock, reset, div_rsp.done, state_ff == dpe_pkg::S_DIV)
   `DPE_ASSERT_NEXT(a_accept_reads, clock, reset, req_valid && !req_stall, state_ff == dpe_pkg::S_READ)

endmodule

@@ sim/tb_dpcm_pixel_encoder_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DPCM pixel encoder testbench
// Drives raster pixels through the encoder under several register settings
// and handshake pressure profiles. Each accepted pixel is encoded by an
// in-bench closed-loop model. Each returned code is compared in order.
// ---------------------------------------------------------------------------
module tb_dpcm_pixel_encoder_top;

   localparam int ROW_DEPTH      = dpe_pkg::MAX_WIDTH_DEFAULT;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 75;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DIR_ROWS       = 33;

   localparam logic [dpe_pkg::CSR_IDX_W-1:0] IDX_WIDTH = dpe_pkg::CSR_LINE_WIDTH;
   localparam logic [dpe_pkg::CSR_IDX_W-1:0] IDX_MODE  = dpe_pkg::CSR_PRED_MODE;
   localparam logic [dpe_pkg::CSR_IDX_W-1:0] IDX_STEP  = dpe_pkg::CSR_QUANT_STEP;

   localparam dpe_pkg::pred_mode_type P_LEFT = dpe_pkg::PRED_LEFT;
   localparam dpe_pkg::pred_mode_type P_AVG  = dpe_pkg::PRED_AVERAGE;
   localparam dpe_pkg::pred_mode_type P_ADA  = dpe_pkg::PRED_ADAPTIVE;
   localparam dpe_pkg::pred_mode_type P_COMP = dpe_pkg::PRED_COMPETITIVE;

   typedef struct packed {
      logic signed [dpe_pkg::CODE_OUT_W-1:0] code;
      dpe_pkg::pred_mode_type                sel;
   } code_item_type;

   typedef struct packed {
      logic                           is_write;
      logic [dpe_pkg::CSR_IDX_W-1:0]  idx;
      logic [dpe_pkg::CSR_DATA_W-1:0] data;
      logic [dpe_pkg::PIX_W-1:0]      pix;
      logic                           fs;
      logic                           typed_in;
      code_item_type                  want;
   } stim_row_type;

   logic                                  clock;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [dpe_pkg::PIX_W-1:0]             req_pixel = '0;
   logic                                  req_frame_start = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [dpe_pkg::CODE_OUT_W-1:0] rsp_residual_code;
   logic [dpe_pkg::MODE_W-1:0]            rsp_predictor_used;
   logic                                  csr_write = 1'b0;
   logic [dpe_pkg::CSR_IDX_W-1:0]         csr_index = '0;
   logic [dpe_pkg::CSR_DATA_W-1:0]        csr_data = '0;

   // encoder model state and register copy
   int                         row_recon [ROW_DEPTH];
   bit                         row_written [ROW_DEPTH];
   int                         left_recon;
   int                         upleft_recon;
   int                         col_idx;
   bit                         first_row;
   logic [dpe_pkg::LW_W-1:0]   cfg_width;
   dpe_pkg::pred_mode_type     cfg_mode;
   logic [dpe_pkg::STEP_W-1:0] cfg_step;

   code_item_type pending_codes [$];
   int            errors = 0;
   int            idle_cycles = 0;
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   int            last_pix = 128;

   dpcm_pixel_encoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_residual_code  (rsp_residual_code),
      .rsp_predictor_used (rsp_predictor_used),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int abs_diff(int x, int y);
      return (x > y) ? x - y : y - x;
   endfunction

   function automatic int eff_width();
      int w;
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > ROW_DEPTH) w = ROW_DEPTH;
      return w;
   endfunction

   function automatic code_item_type encode_pixel(logic [dpe_pkg::PIX_W-1:0] pix, logic fs);
      int x, w, q, j, a, b, c, p_left, p_avg, p_ada, pred, num, den, code, recon;
      int da, db, dc;
      dpe_pkg::pred_mode_type sel;
      code_item_type res;
      x = pix;
      w = eff_width();
      q = (cfg_step == 0) ? 1 : int'(cfg_step);
      if (fs) begin
         col_idx = 0;
         first_row = 1'b1;
         left_recon = 128;
         upleft_recon = 128;
      end
      // width shrunk below the current column: wrap into a new row
      if (col_idx >= w) begin
         col_idx = 0;
         first_row = 1'b0;
      end
      j = col_idx;
      a = first_row ? 128 : row_recon[j];
      b = (first_row || j == 0) ? 128 : upleft_recon;
      c = (j == 0) ? 128 : left_recon;
      p_left = c;
      p_avg = (first_row && j == 0) ? 128 : ((a + c) >>> 1);
      p_ada = (abs_diff(c, b) < abs_diff(a, b)) ? a : b;
      if (cfg_mode == P_COMP) begin
         da = abs_diff(x, p_left);
         db = abs_diff(x, p_avg);
         dc = abs_diff(x, p_ada);
         if (da < db && da < dc) sel = P_LEFT;
         else if (db < dc) sel = P_AVG;
         else sel = P_ADA;
      end else begin
         sel = cfg_mode;
      end
      pred = (sel == P_LEFT) ? p_left : (sel == P_AVG) ? p_avg : p_ada;
      // round half up: floor((2d + q) / 2q)
      num = 2 * (x - pred) + q;
      den = 2 * q;
      code = (num >= 0) ? num / den : -((-num + den - 1) / den);
      recon = pred + code * q;
      upleft_recon = a;
      row_recon[j] = recon;
      row_written[j] = 1'b1;
      left_recon = recon;
      col_idx = j + 1;
      if (col_idx >= w) begin
         col_idx = 0;
         first_row = 1'b0;
      end
      res.code = dpe_pkg::CODE_OUT_W'(code + 128);
      res.sel = sel;
      return res;
   endfunction

   // true when the next pixel without a frame start would read a row entry never stored
   function automatic bit reads_unwritten();
      int j;
      bit fr;
      j = col_idx;
      fr = first_row;
      if (j >= eff_width()) begin
         j = 0;
         fr = 1'b0;
      end
      return !fr && !row_written[j];
   endfunction

   function automatic logic [dpe_pkg::PIX_W-1:0] next_pixel();
      int r, v;
      r = $urandom_range(99);
      if (r < 10) begin
         v = ($urandom_range(1) == 1) ? 255 : 0;
      end else if (r < 35) begin
         v = $urandom_range(255);
      end else begin
         // smooth image content around the last sample
         v = last_pix + int'($urandom_range(24)) - 12;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
      end
      last_pix = v;
      return dpe_pkg::PIX_W'(v);
   endfunction

   task automatic send_pixel(input logic [dpe_pkg::PIX_W-1:0] pix, input logic fs,
                             input logic typed_in, input code_item_type want);
      code_item_type predicted;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = encode_pixel(pix, fs);
      pending_codes.push_back(typed_in ? want : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [dpe_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dpe_pkg::CSR_DATA_W-1:0] data);
      settle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         IDX_WIDTH: cfg_width = data;
         IDX_MODE:  cfg_mode = dpe_pkg::pred_mode_type'(data[dpe_pkg::MODE_W-1:0]);
         IDX_STEP:  cfg_step = data[dpe_pkg::STEP_W-1:0];
         default: ;
      endcase
   endtask

   initial begin : stimulus
      stim_row_type dir_rows [DIR_ROWS];
      stim_row_type row;
      logic fs;
      int r;
      logic [dpe_pkg::CSR_DATA_W-1:0] width_val;
      logic [dpe_pkg::CSR_DATA_W-1:0] step_val;

      // write?, index, data, pixel, frame start, typed-in?, expected {code, predictor}
      dir_rows = '{
         // defaults: full width, left predictor, unit step
         '{1'b0, IDX_WIDTH, 11'd0, 8'd0,   1'b1, 1'b1, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd255, 1'b1, 1'b1, '{10'sd255, P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd128, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b1, IDX_WIDTH, 11'd3, 8'd0,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b1, IDX_MODE,  11'(P_AVG), 8'd0, 1'b0, 1'b0, '{10'sd0, P_LEFT}},
         '{1'b1, IDX_STEP,  11'd64, 8'd0,  1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd255, 1'b1, 1'b1, '{10'sd130, P_AVG}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd0,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd200, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd17,  1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd90,  1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd3,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         // adaptive, zero step taken as one
         '{1'b1, IDX_MODE,  11'(P_ADA), 8'd0, 1'b0, 1'b0, '{10'sd0, P_LEFT}},
         '{1'b1, IDX_STEP,  11'd0, 8'd0,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd0,   1'b1, 1'b1, '{10'sd0,   P_ADA}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd255, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd255, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd0,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd128, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd60,  1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         // competitive, largest step, zero width taken as one
         '{1'b1, IDX_MODE,  11'(P_COMP), 8'd0, 1'b0, 1'b0, '{10'sd0, P_LEFT}},
         '{1'b1, IDX_STEP,  11'd127, 8'd0, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b1, IDX_WIDTH, 11'd0, 8'd0,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd255, 1'b1, 1'b1, '{10'sd129, P_ADA}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd0,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd255, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd100, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         // width beyond the row memory, clipped
         '{1'b1, IDX_WIDTH, 11'd2047, 8'd0, 1'b0, 1'b0, '{10'sd0,  P_LEFT}},
         '{1'b1, IDX_STEP,  11'd1, 8'd0,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd7,   1'b1, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd250, 1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd3,   1'b0, 1'b0, '{10'sd0,   P_LEFT}},
         '{1'b0, IDX_WIDTH, 11'd0, 8'd128, 1'b0, 1'b0, '{10'sd0,   P_LEFT}}
      };

      left_recon = 128;
      upleft_recon = 128;
      col_idx = 0;
      first_row = 1'b1;
      cfg_width = dpe_pkg::LINE_WIDTH_RESET;
      cfg_mode = P_LEFT;
      cfg_step = dpe_pkg::QUANT_STEP_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_write) write_reg(row.idx, row.data);
         else send_pixel(row.pix, row.fs, row.typed_in, row.want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 73;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 73;
            end
            default: begin
               send_idle_pct = 13;
               stall_pct = 13;
            end
         endcase
         // mostly narrow rows so that the above neighbors get exercised
         r = $urandom_range(9);
         case (r)
            0: width_val = '0;
            1: width_val = 11'd2047;
            2: width_val = dpe_pkg::CSR_DATA_W'(dpe_pkg::MAX_WIDTH_DEFAULT);
            3: width_val = dpe_pkg::CSR_DATA_W'($urandom_range(2047));
            default: width_val = dpe_pkg::CSR_DATA_W'($urandom_range(12, 1));
         endcase
         r = $urandom_range(9);
         case (r)
            0: step_val = '0;
            1: step_val = 11'd127;
            2: step_val = 11'd64;
            3: step_val = 11'd1;
            default: step_val = dpe_pkg::CSR_DATA_W'($urandom_range(63, 2));
         endcase
         write_reg(IDX_WIDTH, width_val);
         write_reg(IDX_MODE, dpe_pkg::CSR_DATA_W'($urandom_range(3)));
         write_reg(IDX_STEP, step_val);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // force a new image where a grown width would expose unstored row entries
            fs = ($urandom_range(63) == 0) || reads_unwritten();
            send_pixel(next_pixel(), fs, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin : rsp_check
      code_item_type want;
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_codes.size() == 0) begin
            $display("%0t: unexpected transaction, code %0d predictor %0d",
                     $time, rsp_residual_code, rsp_predictor_used);
            errors++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_residual_code !== want.code) begin
               $display("%0t: residual_code mismatch, expected %0d, actual %0d",
                        $time, want.code, rsp_residual_code);
               errors++;
            end
            if (rsp_predictor_used !== want.sel) begin
               $display("%0t: predictor_used mismatch, expected %0d, actual %0d",
                        $time, want.sel, rsp_predictor_used);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dpe_pkg.sv
hdl/dpe_row_mem.sv
hdl/dpe_predictor.sv
hdl/dpe_divider.sv
hdl/dpcm_pixel_encoder_top.sv
sim/tb_dpcm_pixel_encoder_top.sv
